// File: rtl/core/wtsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared widths, codes and types of the world to screen projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  // fixed point format of matrix entries and coordinates
  localparam int COORD_FRAC_BITS = 12;
  localparam int WORD_W          = 32;
  localparam int PROD_W          = 2 * WORD_W;
  // dot product: three floored products plus one entry
  localparam int DOT_W           = PROD_W - COORD_FRAC_BITS + 2;

  // screen size and scale factor k = 8 * size
  localparam int DIM_W           = 14;
  localparam int K_W             = DIM_W + 3;

  // quotient: integer part below 2^CLIP_SHIFT, times k
  localparam int CLIP_SHIFT      = 19;
  localparam int QBITS           = CLIP_SHIFT + K_W;
  localparam int QIDX_W          = $clog2(QBITS);
  localparam int NUM_W           = DOT_W + K_W;
  localparam int LO_W            = DOT_W / 2;
  localparam int HI_W            = DOT_W - LO_W;
  localparam int QS_W            = QBITS + 2;
  localparam int PX_W            = QS_W + 1;

  // pixel output range
  localparam int PIX_W           = 19;
  localparam int QUOT_CLIP       = 4194304;
  localparam int PIX_MAX         = 262143;
  localparam int PIX_MIN         = -262144;

  // configuration port
  localparam int N_MAT           = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FIRST  = 3'd0,
    REG_X_SECOND = 3'd1,
    REG_Y_FIRST  = 3'd2,
    REG_Y_SECOND = 3'd3,
    REG_W_FIRST  = 3'd4,
    REG_W_SECOND = 3'd5,
    REG_SCR_W    = 3'd6,
    REG_SCR_H    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_ON     = 2'd0,
    STATUS_BEHIND = 2'd1,
    STATUS_OFF    = 2'd2
  } status_e;

  typedef struct packed {
    logic [N_MAT-1:0][WORD_W-1:0] mat;
    logic [DIM_W-1:0]             scr_w;
    logic [DIM_W-1:0]             scr_h;
  } cfg_t;

  // one axis on its way into the divider
  typedef struct packed {
    logic             neg;
    logic             clip;
    logic [NUM_W-1:0] num;
  } lane_t;

  typedef struct packed {
    logic             behind;
    logic [DOT_W-1:0] den;
    lane_t            x;
    lane_t            y;
  } front_t;

  // one axis out of the divider
  typedef struct packed {
    logic             neg;
    logic             clip;
    logic [QBITS-1:0] q;
    logic             remnz;
  } quo_t;

  typedef struct packed {
    logic  behind;
    quo_t  x;
    quo_t  y;
  } div_out_t;

endpackage

// File: rtl/core/wtsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_front
// Dot products, camera test, magnitudes, clip test and numerators n = |dot| * 8 * size.
// Five register stages with valid bits that travel with the data.
// ----------------------------------------------------------------------------
module wtsp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wtsp_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [wtsp_pkg::WORD_W-1:0] world_x_i,
  input  logic signed [wtsp_pkg::WORD_W-1:0] world_y_i,
  input  logic signed [wtsp_pkg::WORD_W-1:0] world_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wtsp_pkg::front_t              out_o
);
  import wtsp_pkg::*;

  localparam int NS    = 5;
  localparam int W100W = DOT_W + 8;
  localparam logic signed [W100W-1:0] BEHIND_LIM = W100W'(2 ** COORD_FRAC_BITS);

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  // bubble collapsing ready chain
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = ~v_q[i] | rdy[i+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= (i == 0) ? in_valid_i : v_q[i-1];
        end
      end
    end
  end

  // floor to the coordinate grid and extend to dot width
  function automatic logic signed [DOT_W-1:0] fl(input logic signed [PROD_W-1:0] p);
    return {{2{p[PROD_W-1]}}, p[PROD_W-1:COORD_FRAC_BITS]};
  endfunction

  function automatic logic signed [DOT_W-1:0] ext(input logic [WORD_W-1:0] m);
    return {{(DOT_W-WORD_W){m[WORD_W-1]}}, m};
  endfunction

  // stage 0: nine products
  logic signed [WORD_W-1:0] coord [3];
  logic signed [PROD_W-1:0] p_q   [9];

  assign coord[0] = world_x_i;
  assign coord[1] = world_y_i;
  assign coord[2] = world_z_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[3*r+c] <= $signed(cfg_i.mat[4*r+c]) * coord[c];
        end
      end
    end
  end

  // stage 1: row sums
  logic signed [DOT_W-1:0] dx_q, dy_q, w_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      dx_q <= fl(p_q[0]) + fl(p_q[1]) + fl(p_q[2]) + ext(cfg_i.mat[3]);
      dy_q <= fl(p_q[3]) + fl(p_q[4]) + fl(p_q[5]) + ext(cfg_i.mat[7]);
      w_q  <= fl(p_q[6]) + fl(p_q[7]) + fl(p_q[8]) + ext(cfg_i.mat[11]);
    end
  end

  // stage 2: camera test and magnitudes
  logic signed [W100W-1:0] w_ext, w100;
  logic                    behind2_q, negx2_q, negy2_q;
  logic [DOT_W-1:0]        mx_q, my_q, den2_q;

  always_comb begin
    w_ext = {{(W100W-DOT_W){w_q[DOT_W-1]}}, w_q};
    w100  = (w_ext <<< 6) + (w_ext <<< 5) + (w_ext <<< 2);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      behind2_q <= w100 < BEHIND_LIM;
      negx2_q   <= dx_q[DOT_W-1];
      negy2_q   <= (dy_q != '0) && !dy_q[DOT_W-1];
      mx_q      <= dx_q[DOT_W-1] ? DOT_W'(-dx_q) : DOT_W'(dx_q);
      my_q      <= dy_q[DOT_W-1] ? DOT_W'(-dy_q) : DOT_W'(dy_q);
      den2_q    <= DOT_W'(w_q);
    end
  end

  // stage 3: clip test and split products with k
  logic [K_W-1:0]        kx, ky;
  logic                  behind3_q, negx3_q, negy3_q, clipx_q, clipy_q;
  logic [DOT_W-1:0]      den3_q;
  logic [LO_W+K_W-1:0]   xlo_q, ylo_q;
  logic [HI_W+K_W-1:0]   xhi_q, yhi_q;

  assign kx = {cfg_i.scr_w, 3'b000};
  assign ky = {cfg_i.scr_h, 3'b000};

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      behind3_q <= behind2_q;
      negx3_q   <= negx2_q;
      negy3_q   <= negy2_q;
      den3_q    <= den2_q;
      clipx_q   <= {{CLIP_SHIFT{1'b0}}, mx_q} >= {den2_q, {CLIP_SHIFT{1'b0}}};
      clipy_q   <= {{CLIP_SHIFT{1'b0}}, my_q} >= {den2_q, {CLIP_SHIFT{1'b0}}};
      xlo_q     <= mx_q[LO_W-1:0] * kx;
      xhi_q     <= mx_q[DOT_W-1:LO_W] * kx;
      ylo_q     <= my_q[LO_W-1:0] * ky;
      yhi_q     <= my_q[DOT_W-1:LO_W] * ky;
    end
  end

  // stage 4: join partial products
  front_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      out_q.behind <= behind3_q;
      out_q.den    <= den3_q;
      out_q.x.neg  <= negx3_q;
      out_q.x.clip <= clipx_q;
      out_q.x.num  <= NUM_W'(xlo_q) + (NUM_W'(xhi_q) << LO_W);
      out_q.y.neg  <= negy3_q;
      out_q.y.clip <= clipy_q;
      out_q.y.num  <= NUM_W'(ylo_q) + (NUM_W'(yhi_q) << LO_W);
    end
  end

  assign out_o = out_q;

endmodule

// File: rtl/core/wtsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_div
// Pipelined restoring divider, one quotient bit per stage, x and y side by
// side over a shared denominator.
// ----------------------------------------------------------------------------
module wtsp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wtsp_pkg::front_t    in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wtsp_pkg::div_out_t  out_o
);
  import wtsp_pkg::*;

  localparam int NS = QBITS;

  typedef struct packed {
    logic             neg;
    logic             clip;
    logic [NUM_W-1:0] num;
    logic [DOT_W-1:0] rem;
    logic [QBITS-1:0] q;
  } dlane_t;

  typedef struct packed {
    logic             behind;
    logic [DOT_W-1:0] den;
    dlane_t           x;
    dlane_t           y;
  } dstage_t;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  // bubble collapsing ready chain
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = ~v_q[i] | rdy[i+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= (i == 0) ? in_valid_i : v_q[i-1];
        end
      end
    end
  end

  // top numerator bits start the remainder
  function automatic dlane_t lane_init(input lane_t l);
    dlane_t r;
    r.neg  = l.neg;
    r.clip = l.clip;
    r.num  = l.num;
    r.rem  = DOT_W'(l.num[NUM_W-1:QBITS]);
    r.q    = '0;
    return r;
  endfunction

  // one restoring step: bring down a bit, subtract when it fits
  function automatic dlane_t lane_step(input dlane_t l, input logic [DOT_W-1:0] den,
                                       input logic [QIDX_W-1:0] bidx);
    dlane_t        r;
    logic [DOT_W:0] t;
    r = l;
    t = {l.rem, l.num[bidx]};
    if (t >= {1'b0, den}) begin
      t       = t - {1'b0, den};
      r.q[bidx] = 1'b1;
    end
    r.rem = t[DOT_W-1:0];
    return r;
  endfunction

  dstage_t src;
  dstage_t st_q [NS];
  dstage_t st_d [NS];

  always_comb begin
    src.behind = in_i.behind;
    src.den    = in_i.den;
    src.x      = lane_init(in_i.x);
    src.y      = lane_init(in_i.y);
  end

  // next value of every stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      st_d[k]   = (k == 0) ? src : st_q[k-1];
      st_d[k].x = lane_step(st_d[k].x, st_d[k].den, QIDX_W'(NS - 1 - k));
      st_d[k].y = lane_step(st_d[k].y, st_d[k].den, QIDX_W'(NS - 1 - k));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // quotient and sticky remainder out
  always_comb begin
    out_o.behind  = st_q[NS-1].behind;
    out_o.x.neg   = st_q[NS-1].x.neg;
    out_o.x.clip  = st_q[NS-1].x.clip;
    out_o.x.q     = st_q[NS-1].x.q;
    out_o.x.remnz = |st_q[NS-1].x.rem;
    out_o.y.neg   = st_q[NS-1].y.neg;
    out_o.y.clip  = st_q[NS-1].y.clip;
    out_o.y.q     = st_q[NS-1].y.q;
    out_o.y.remnz = |st_q[NS-1].y.rem;
  end

endmodule

// File: rtl/core/wtsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_back
// Signed floor quotient, viewport offset, saturation and screen test.
// Two register stages; the second is the output register.
// ----------------------------------------------------------------------------
module wtsp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wtsp_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wtsp_pkg::div_out_t            in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [wtsp_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [wtsp_pkg::PIX_W-1:0] pixel_y_o
);
  import wtsp_pkg::*;

  localparam int NS = 2;
  localparam logic signed [PX_W-1:0] P_MAX = PX_W'(PIX_MAX);
  localparam logic signed [PX_W-1:0] P_MIN = PX_W'(PIX_MIN);

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  // bubble collapsing ready chain
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = ~v_q[i] | rdy[i+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= (i == 0) ? in_valid_i : v_q[i-1];
        end
      end
    end
  end

  // floor of the signed scaled quotient
  function automatic logic signed [QS_W-1:0] sq(input quo_t v, input logic kzero);
    logic signed [QS_W-1:0] m;
    m = QS_W'(v.q);
    if (kzero) begin
      return '0;
    end else if (v.clip) begin
      return v.neg ? -QS_W'(QUOT_CLIP) : QS_W'(QUOT_CLIP);
    end else if (v.neg) begin
      return -(m + QS_W'(v.remnz));
    end
    return m;
  endfunction

  function automatic logic signed [PX_W-1:0] clamp(input logic signed [PX_W-1:0] v);
    if (v > P_MAX) begin
      return P_MAX;
    end else if (v < P_MIN) begin
      return P_MIN;
    end
    return v;
  endfunction

  // stage 0: add viewport offsets
  logic signed [PX_W-1:0] base_x, base_y;
  logic signed [PX_W-1:0] px_q, py_q;
  logic                   behind_q;

  assign base_x = PX_W'({cfg_i.scr_w[DIM_W-1:1], 4'b1000});
  assign base_y = PX_W'({cfg_i.scr_h[DIM_W-1:1], 4'b0000}) - PX_W'(8);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      behind_q <= in_i.behind;
      px_q     <= base_x + PX_W'(sq(in_i.x, cfg_i.scr_w == '0));
      py_q     <= base_y + PX_W'(sq(in_i.y, cfg_i.scr_h == '0));
    end
  end

  // stage 1: saturate and classify
  logic signed [PX_W-1:0] cx, cy, lim_x, lim_y;
  logic [1:0]             status_q;
  logic signed [PIX_W-1:0] pxo_q, pyo_q;

  always_comb begin
    cx    = clamp(px_q);
    cy    = clamp(py_q);
    lim_x = PX_W'({cfg_i.scr_w, 4'b0000});
    lim_y = PX_W'({cfg_i.scr_h, 4'b0000});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      if (behind_q) begin
        status_q <= STATUS_BEHIND;
        pxo_q    <= '0;
        pyo_q    <= '0;
      end else begin
        status_q <= (cx < 0 || cx > lim_x || cy < 0 || cy > lim_y) ? STATUS_OFF : STATUS_ON;
        pxo_q    <= cx[PIX_W-1:0];
        pyo_q    <= cy[PIX_W-1:0];
      end
    end
  end

  assign status_o  = status_q;
  assign pixel_x_o = pxo_q;
  assign pixel_y_o = pyo_q;

endmodule

// File: rtl/core/world_to_screen_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects world points through a view matrix to saturated pixel positions.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o) takes one world point per beat, signed
//   Q20.12 x, y and z. out channel (out_valid_o/out_ready_i) gives one beat
//   per point: status (on screen, behind camera, off screen) and pixel x/y
//   in sixteenths of a pixel, saturated to 19 bits, zero when behind.
//   cfg channel writes the x, y and w matrix rows as pairs of Q20.12 words
//   and the screen size; it is always ready, write only while idle.
//   The pipeline has five stages of products, sums and numerator
//   scaling, 36 stages of the shared x/y restoring divider (one quotient bit
//   each), two stages of offset, saturation and screen test.
//   Throughput is one point per cycle while the receiver takes every beat.
//   Reset clears all pipeline valid bits, the matrix to zero and the screen
//   to 1920 by 1080. When the receiver stalls, stages still fill up behind
//   the output register; input stalls only once every stage holds a point.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wtsp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [wtsp_pkg::WORD_W-1:0]    world_x_i,
  input  logic signed [wtsp_pkg::WORD_W-1:0]    world_y_i,
  input  logic signed [wtsp_pkg::WORD_W-1:0]    world_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            status_o,
  output logic signed [wtsp_pkg::PIX_W-1:0]     pixel_x_o,
  output logic signed [wtsp_pkg::PIX_W-1:0]     pixel_y_o
);
  import wtsp_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mat   <= '0;
      cfg_q.scr_w <= DIM_W'(1920);
      cfg_q.scr_h <= DIM_W'(1080);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_FIRST, REG_X_SECOND, REG_Y_FIRST,
        REG_Y_SECOND, REG_W_FIRST, REG_W_SECOND: begin
          cfg_q.mat[{cfg_index_i, 1'b0}] <= cfg_data_i[WORD_W-1:0];
          cfg_q.mat[{cfg_index_i, 1'b1}] <= cfg_data_i[2*WORD_W-1:WORD_W];
        end
        REG_SCR_W: begin
          cfg_q.scr_w <= cfg_data_i[DIM_W-1:0];
        end
        REG_SCR_H: begin
          cfg_q.scr_h <= cfg_data_i[DIM_W-1:0];
        end
      endcase
    end
  end

  // front: dot products and numerators
  logic     f_valid, f_ready;
  front_t   f_data;

  wtsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .world_x_i   (world_x_i),
    .world_y_i   (world_y_i),
    .world_z_i   (world_z_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_o       (f_data)
  );

  // divider
  logic      d_valid, d_ready;
  div_out_t  d_data;

  wtsp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_i        (f_data),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_o       (d_data)
  );

  // viewport mapping and output register
  wtsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_i        (d_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o)
  );

`ifndef NO_ASSERTIONS
  // behind camera always reports zero pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_BEHIND |-> pixel_x_o == '0 && pixel_y_o == '0)
    else $error("behind camera with nonzero pixels");

  // on screen implies both coordinates nonnegative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_ON |-> !pixel_x_o[PIX_W-1] && !pixel_y_o[PIX_W-1])
    else $error("on screen with negative pixel");

  // input only stalls when the output beat is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");
`endif

endmodule

// File: tb/world_to_screen_projection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_tb
// Self-checking bench for the projection pipeline: a directed table of
// points, then random points under several matrix and screen settings, with
// random gaps on both channels and a long receiver stall. Every output beat
// is compared with a table value or an in-bench fixed-point projection.
// ----------------------------------------------------------------------------
module world_to_screen_projection_tb;
  import wtsp_pkg::*;

  localparam int N_PHASES     = 8;
  localparam int PHASE_POINTS = 250;
  localparam int DRAIN_CYCLES = 60;
  localparam int Q_ONE        = 1 << COORD_FRAC_BITS;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              known;
    status_e           st;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
  } dir_row_t;

  typedef struct packed {
    status_e          st;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
  } pixel_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [WORD_W-1:0]      world_x_i = '0;
  logic [WORD_W-1:0]      world_y_i = '0;
  logic [WORD_W-1:0]      world_z_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             status_o;
  logic [PIX_W-1:0]       pixel_x_o;
  logic [PIX_W-1:0]       pixel_y_o;

  // bench copy of the configuration
  longint          view_mat [N_MAT];
  longint unsigned scr_w, scr_h;

  pixel_beat_t pending_pixels [$];
  int          n_fail = 0;
  int          long_hold = 0;
  bit          quiet = 1'b0;

  world_to_screen_projection dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint row_dot(int base, longint x, longint y, longint z);
    return ((view_mat[base] * x) >>> COORD_FRAC_BITS)
         + ((view_mat[base+1] * y) >>> COORD_FRAC_BITS)
         + ((view_mat[base+2] * z) >>> COORD_FRAC_BITS)
         + view_mat[base+3];
  endfunction

  // floor(num * k / den), quotient magnitude clipped
  function automatic longint scaled_quot(longint num, longint unsigned k, longint den);
    longint unsigned mag, d, a, r, frac, rem, q;
    mag  = (num < 0) ? longint'(-num) : num;
    d    = den;
    a    = mag / d;
    r    = mag % d;
    frac = 0;
    rem  = 0;
    if (k == 0) return 0;
    if (a >= (64'd1 << CLIP_SHIFT))
      return (num < 0) ? -longint'(QUOT_CLIP) : longint'(QUOT_CLIP);
    for (int b = K_W - 1; b >= 0; b--) begin
      frac = frac << 1;
      rem  = rem << 1;
      if (k[b]) rem += r;
      while (rem >= d) begin
        rem -= d;
        frac++;
      end
    end
    q = a * k + frac;
    if (num >= 0) return q;
    return -longint'(q + ((rem != 0) ? 1 : 0));
  endfunction

  function automatic longint clamp_pix(longint v);
    if (v > PIX_MAX) return PIX_MAX;
    if (v < PIX_MIN) return PIX_MIN;
    return v;
  endfunction

  function automatic pixel_beat_t project_point(logic [WORD_W-1:0] wx,
                                                logic [WORD_W-1:0] wy,
                                                logic [WORD_W-1:0] wz);
    longint      x, y, z, w, px, py;
    pixel_beat_t r;
    x = longint'($signed(wx));
    y = longint'($signed(wy));
    z = longint'($signed(wz));
    w = row_dot(8, x, y, z);
    r = '{STATUS_BEHIND, '0, '0};
    if (w * 100 < Q_ONE) return r;
    px = 16 * longint'(scr_w >> 1) + 8 + scaled_quot(row_dot(0, x, y, z), 8 * scr_w, w);
    py = 16 * longint'(scr_h >> 1) - 8 + scaled_quot(-row_dot(4, x, y, z), 8 * scr_h, w);
    px = clamp_pix(px);
    py = clamp_pix(py);
    r.st = STATUS_ON;
    if (px < 0 || px > 16 * longint'(scr_w) || py < 0 || py > 16 * longint'(scr_h))
      r.st = STATUS_OFF;
    r.px = px[PIX_W-1:0];
    r.py = py[PIX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx <= REG_W_SECOND) begin
      view_mat[2*idx]   = longint'($signed(data[31:0]));
      view_mat[2*idx+1] = longint'($signed(data[63:32]));
    end else if (idx == REG_SCR_W) begin
      scr_w = 64'(data[DIM_W-1:0]);
    end else begin
      scr_h = 64'(data[DIM_W-1:0]);
    end
    @(posedge clk_i);
  endtask

  // one point beat; the expectation is queued at the accepting edge
  task automatic send_point(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                            logic [WORD_W-1:0] z, bit use_known, pixel_beat_t known);
    in_valid_i <= 1'b1;
    world_x_i  <= x;
    world_y_i  <= y;
    world_z_i  <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_pixels.push_back(use_known ? known : project_point(x, y, z));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- checker

  initial begin
    pixel_beat_t exp_pix;
    int          burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          $error("output beat with nothing expected");
          n_fail++;
        end else begin
          exp_pix = pending_pixels.pop_front();
          if (status_o !== exp_pix.st) begin
            $error("status expected %0d got %0d", exp_pix.st, status_o);
            n_fail++;
          end
          if (pixel_x_o !== exp_pix.px) begin
            $error("pixel_x expected %0d got %0d", $signed(exp_pix.px), $signed(pixel_x_o));
            n_fail++;
          end
          if (pixel_y_o !== exp_pix.py) begin
            $error("pixel_y expected %0d got %0d", $signed(exp_pix.py), $signed(pixel_y_o));
            n_fail++;
          end
        end
      end
      // receiver backpressure: long hold, random bursts, or always ready
      if (long_hold > 0) begin
        long_hold--;
        out_ready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [WORD_W-1:0] rand_entry(bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
  endfunction

  function automatic logic [WORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 32 * Q_ONE) - 16 * Q_ONE;
    endcase
  endfunction

  initial begin
    dir_row_t    dir_tab [];
    pixel_beat_t behind0, centre;
    logic [WORD_W-1:0] a, b, c, d;
    logic [DIM_W-1:0]  sw, sh;
    bit                wide;

    behind0 = '{STATUS_BEHIND, '0, '0};
    centre  = '{STATUS_ON, 19'(16 * 960 + 8), 19'(16 * 540 - 8)};
    foreach (view_mat[i]) view_mat[i] = 0;
    scr_w = 1920;
    scr_h = 1080;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero matrix after reset: w is zero, so every point is behind
    dir_tab = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, STATUS_BEHIND, 19'd0, 19'd0},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, STATUS_BEHIND, 19'd0, 19'd0},
      '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, STATUS_BEHIND, 19'd0, 19'd0},
      '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1, STATUS_BEHIND, 19'd0, 19'd0}
    };
    foreach (dir_tab[i])
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, 1'b1,
                 '{dir_tab[i].st, dir_tab[i].px, dir_tab[i].py});
    drain();

    // identity-like view: x, y pass through, w follows z
    write_reg(REG_X_FIRST,  64'(Q_ONE));
    write_reg(REG_Y_FIRST,  {32'(Q_ONE), 32'h0});
    write_reg(REG_W_SECOND, 64'(Q_ONE));
    dir_tab = '{
      '{32'h0, 32'h0, 32'(Q_ONE), 1'b1, STATUS_ON, centre.px, centre.py},
      '{32'h0, 32'h0, 32'd40, 1'b1, STATUS_BEHIND, 19'd0, 19'd0},
      '{32'h0, 32'h0, -32'(Q_ONE), 1'b1, STATUS_BEHIND, 19'd0, 19'd0},
      '{32'h0, 32'h0, 32'd41, 1'b0, STATUS_ON, 19'd0, 19'd0},
      '{32'h7FFFFFFF, 32'h80000000, 32'd41, 1'b0, STATUS_ON, 19'd0, 19'd0},
      '{32'h80000000, 32'h7FFFFFFF, 32'd41, 1'b0, STATUS_ON, 19'd0, 19'd0},
      '{32'(Q_ONE), 32'h0, 32'(Q_ONE), 1'b0, STATUS_ON, 19'd0, 19'd0},
      '{-32'(Q_ONE), -32'(Q_ONE), 32'(Q_ONE), 1'b0, STATUS_ON, 19'd0, 19'd0},
      '{32'd2047, 32'hFFFFF801, 32'(Q_ONE), 1'b0, STATUS_ON, 19'd0, 19'd0},
      '{32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF, 1'b0, STATUS_ON, 19'd0, 19'd0}
    };
    foreach (dir_tab[i])
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].known,
                 '{dir_tab[i].st, dir_tab[i].px, dir_tab[i].py});
    drain();

    // random phases, each with its own matrix and screen
    for (int p = 0; p < N_PHASES; p++) begin
      wide = (p == 1);
      for (int r = REG_X_FIRST; r <= REG_W_SECOND; r++) begin
        a = rand_entry(wide);
        b = rand_entry(wide);
        if (r == REG_W_SECOND && !wide) b = $urandom_range(0, 64 * Q_ONE);
        if (p == 2 && r <= REG_W_SECOND) begin
          a = (r % 2) ? 32'h80000000 : 32'h7FFFFFFF;
          b = (r % 2) ? 32'h7FFFFFFF : 32'h80000000;
        end
        write_reg(cfg_reg_e'(r), {b, a});
      end
      sw = (p == 0) ? 14'd1 : (p == N_PHASES - 1) ? 14'd16383 :
           DIM_W'($urandom_range(1, 16383));
      sh = (p == 0) ? 14'd1 : (p == N_PHASES - 1) ? 14'd16383 :
           DIM_W'($urandom_range(1, 16383));
      c = $urandom;
      d = $urandom;
      write_reg(REG_SCR_W, {c, d[31:DIM_W], sw});
      write_reg(REG_SCR_H, {d, c[31:DIM_W], sh});
      quiet = (p == N_PHASES - 1);
      if (p == 3) long_hold = 200;
      for (int i = 0; i < PHASE_POINTS; i++) begin
        if (p == 5 && i == PHASE_POINTS / 2) drain();
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, behind0);
      end
      drain();
    end

    if (n_fail == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_pixels.size() != 0) $error("%0d results never arrived", pending_pixels.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/wtsp_pkg.sv
rtl/core/wtsp_front.sv
rtl/core/wtsp_div.sv
rtl/core/wtsp_back.sv
rtl/core/world_to_screen_projection.sv
tb/world_to_screen_projection_tb.sv
